### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is switched off while reset is high.
`define SVA_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication that is checked in every cycle, reset included.
`define SVA_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/uvsph_pkg.sv
// ---------------------------------------------------------------------------
// UV sphere vertex generator package
// Widths, register indexes, CORDIC constants and pipeline types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package uvsph_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 160;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENT_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RING_COUNT = 8'd1;

   localparam logic [7:0] SEGMENT_RESET = 8'd32;
   localparam logic [7:0] RING_RESET = 8'd16;
   localparam logic [7:0] SEGMENT_MIN = 8'd3;
   localparam logic [7:0] RING_MIN = 8'd2;

   // Long division: 5 stages of 7 quotient bits each.
   localparam int DIV_STAGES = 5;
   localparam int DIV_STEPS = 7;
   localparam int DIV_QW = DIV_STAGES * DIV_STEPS + 1;

   localparam int CORDIC_STEPS = 24;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
      32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
      32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
      32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C,
      32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
      32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
   };

   // Stage numbering of the pipeline.
   localparam int PHASE_STAGE = DIV_STAGES;
   localparam int MUL_STAGE = PHASE_STAGE + CORDIC_STEPS + 1;
   localparam int OUT_STAGE = MUL_STAGE + 1;
   localparam int NUM_STAGES = OUT_STAGE + 1;

   typedef struct packed {
      logic [7:0]        r;
      logic [DIV_QW-1:0] q;
   } div_lane_type;

   typedef struct packed {
      div_lane_type th;
      div_lane_type ph;
      logic [7:0]   ds;
      logic [7:0]   dr;
   } div_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [31:0] z;
      logic [1:0]         quad;
   } cord_type;

   typedef struct packed {
      logic        quad_valid;
      logic [15:0] top_left;
      logic [15:0] bottom_left;
      logic [15:0] tex_u;
      logic [15:0] tex_v;
   } side_type;

endpackage

### rtl/core/uv_sphere_vertex_generator_unit.sv
// ---------------------------------------------------------------------------
// UV sphere vertex generator
// Returns normal, position, texture coordinate and quad indices of one
// grid point of a UV sphere.
// ---------------------------------------------------------------------------
// The unit accepts one request per clock unless the result side stalls, and
// offers its vertices in order. It has 32 register stages: a five stage
// long divider, one phase stage that rounds the quotients into angle
// phases and texture coordinates, two 24 stage rotation CORDIC lanes (one
// iteration per stage), one multiply stage and one rounding stage that is
// also the output register. A stall on the result side freezes the whole
// pipeline; the request side stays ready as long as the output register is
// empty or being drained. The segment and ring counts are written through
// the csr_ port; the user must write them only while the unit is idle, as
// the unit does not enforce it. Counts below 3 and 2 are raised to those
// minimums, and indices above the counts are clamped to them.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // ring_index [7:0], segment_index [15:8]
   input  logic [uvsph_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // normal_x, normal_y, normal_z, pos_x, pos_y, pos_z, tex_u, tex_v,
   // top_left, bottom_left: 16 bits each from bit 0 up
   output logic [uvsph_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // quad_valid [0]
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [uvsph_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uvsph_pkg::CSR_DATA_W-1:0]  csr_data
);
   import uvsph_pkg::*;

   // Seven steps of restoring division of a remainder below d.
   function automatic div_lane_type div_step(div_lane_type a, logic [7:0] d);
      div_lane_type b;
      logic [8:0]   t;
      b = a;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t = {b.r, 1'b0};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
            b.q = {b.q[DIV_QW-2:0], 1'b1};
         end else begin
            b.q = {b.q[DIV_QW-2:0], 1'b0};
         end
         b.r = t[7:0];
      end
      return b;
   endfunction

   // One CORDIC rotation.
   function automatic cord_type cord_step(cord_type a, int i);
      cord_type           b;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      b = a;
      dx = $signed(a.y) >>> i;
      dy = $signed(a.x) >>> i;
      if (!a.z[31]) begin
         b.x = a.x - dx;
         b.y = a.y + dy;
         b.z = a.z - ATAN_TURN[i];
      end else begin
         b.x = a.x + dx;
         b.y = a.y - dy;
         b.z = a.z + ATAN_TURN[i];
      end
      return b;
   endfunction

   // Round half up after an arithmetic right shift, then saturate.
   function automatic logic [15:0] round_sat(logic signed [67:0] v, int sh,
                                             logic signed [67:0] lim);
      logic signed [67:0] t;
      t = (v + (68'sd1 <<< (sh - 1))) >>> sh;
      if (t > lim) begin
         t = lim;
      end else if (t < -lim) begin
         t = -lim;
      end
      return t[15:0];
   endfunction

   logic [7:0] seg_cnt_ff;
   logic [7:0] ring_cnt_ff;
   logic       adv;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff <= SEGMENT_RESET;
         ring_cnt_ff <= RING_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SEGMENT_COUNT: seg_cnt_ff <= csr_data;
            REG_RING_COUNT:    ring_cnt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register can take a value.
   logic v_ff [NUM_STAGES];

   assign adv = !v_ff[OUT_STAGE] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_tvalid;
         for (int s = 1; s < NUM_STAGES; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // Entry: clamp counts and indices, index arithmetic, first division bits.
   logic [7:0]   segs;
   logic [7:0]   rings;
   logic [7:0]   ring_c;
   logic [7:0]   seg_c;
   logic [17:0]  tl_full;
   logic         quad_ok;
   div_lane_type th0;
   div_lane_type ph0;
   logic [15:0]  tu_val;
   logic [15:0]  tv_val;

   div_type  div_ff [DIV_STAGES];
   div_type  div_in [DIV_STAGES];
   side_type side_ff [MUL_STAGE];
   side_type side_in [MUL_STAGE];

   always_comb begin
      segs = (seg_cnt_ff < SEGMENT_MIN) ? SEGMENT_MIN : seg_cnt_ff;
      rings = (ring_cnt_ff < RING_MIN) ? RING_MIN : ring_cnt_ff;
      ring_c = (req_tdata[7:0] > rings) ? rings : req_tdata[7:0];
      seg_c = (req_tdata[15:8] > segs) ? segs : req_tdata[15:8];
      tl_full = 18'(ring_c) * (18'(segs) + 18'd1) + 18'(seg_c);
      quad_ok = (ring_c < rings) && (seg_c < segs);
      th0.r = (seg_c == segs) ? 8'd0 : seg_c;
      th0.q = DIV_QW'(seg_c == segs);
      ph0.r = (ring_c == rings) ? 8'd0 : ring_c;
      ph0.q = DIV_QW'(ring_c == rings);
      div_in[0].th = div_step(th0, segs);
      div_in[0].ph = div_step(ph0, rings);
      div_in[0].ds = segs;
      div_in[0].dr = rings;
      side_in[0].quad_valid = quad_ok;
      side_in[0].top_left = tl_full[15:0];
      side_in[0].bottom_left = quad_ok ? 16'(tl_full + 18'(segs) + 18'd1) : 16'd0;
      side_in[0].tex_u = 16'd0;
      side_in[0].tex_v = 16'd0;
      for (int k = 1; k < DIV_STAGES; k++) begin
         div_in[k].th = div_step(div_ff[k-1].th, div_ff[k-1].ds);
         div_in[k].ph = div_step(div_ff[k-1].ph, div_ff[k-1].dr);
         div_in[k].ds = div_ff[k-1].ds;
         div_in[k].dr = div_ff[k-1].dr;
      end
      for (int s = 1; s < MUL_STAGE; s++) begin
         side_in[s] = side_ff[s-1];
      end
      side_in[PHASE_STAGE].tex_u = tu_val;
      side_in[PHASE_STAGE].tex_v = tv_val;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
         for (int s = 0; s < MUL_STAGE; s++) begin
            side_ff[s] <= side_in[s];
         end
      end
   end

   // Phase stage: round the quotients into turn phases and texture values.
   // ph_theta = round(seg*2^32/segs) and ph_phi = round(ring*2^31/rings)
   // are both taken as (floor(2x/d) + 1) / 2.
   logic [33:0] q_th;
   logic [32:0] q_ph;
   logic [34:0] th_sum;
   logic [33:0] ph_sum;
   logic [31:0] ph_theta;
   logic [31:0] ph_phi;
   logic [17:0] tu_sum;
   logic [17:0] tv_sum;

   cord_type ct_ff [CORDIC_STEPS+1];
   cord_type cp_ff [CORDIC_STEPS+1];
   cord_type ct_in [CORDIC_STEPS+1];
   cord_type cp_in [CORDIC_STEPS+1];

   always_comb begin
      q_th = div_ff[DIV_STAGES-1].th.q[DIV_QW-1 -: 34];
      q_ph = div_ff[DIV_STAGES-1].ph.q[DIV_QW-1 -: 33];
      th_sum = {1'b0, q_th} + 35'd1;
      ph_sum = {1'b0, q_ph} + 34'd1;
      ph_theta = th_sum[32:1];
      ph_phi = ph_sum[32:1];
      tu_sum = {1'b0, q_th[33:17]} + 18'd1;
      tv_sum = {1'b0, q_ph[32:16]} + 18'd1;
      tu_val = tu_sum[16:1];
      tv_val = 16'(17'd32768 - {1'b0, tv_sum[16:1]});
      ct_in[0].x = CORDIC_X0;
      ct_in[0].y = 34'sd0;
      ct_in[0].z = {2'b00, ph_theta[29:0]};
      ct_in[0].quad = ph_theta[31:30];
      cp_in[0].x = CORDIC_X0;
      cp_in[0].y = 34'sd0;
      cp_in[0].z = {2'b00, ph_phi[29:0]};
      cp_in[0].quad = ph_phi[31:30];
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         ct_in[i+1] = cord_step(ct_ff[i], i);
         cp_in[i+1] = cord_step(cp_ff[i], i);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            ct_ff[i] <= ct_in[i];
            cp_ff[i] <= cp_in[i];
         end
      end
   end

   // Multiply stage: map back to the quadrant and form the products.
   logic signed [33:0] cos_t;
   logic signed [33:0] sin_t;
   logic signed [33:0] cos_p;
   logic signed [33:0] sin_p;
   logic signed [67:0] nx_in;
   logic signed [67:0] nz_in;
   logic signed [67:0] nx_ff;
   logic signed [67:0] nz_ff;
   logic signed [33:0] ny_ff;
   side_type           side_mul_ff;

   always_comb begin
      case (ct_ff[CORDIC_STEPS].quad)
         2'd0: begin
            cos_t = ct_ff[CORDIC_STEPS].x;
            sin_t = ct_ff[CORDIC_STEPS].y;
         end
         2'd1: begin
            cos_t = -ct_ff[CORDIC_STEPS].y;
            sin_t = ct_ff[CORDIC_STEPS].x;
         end
         2'd2: begin
            cos_t = -ct_ff[CORDIC_STEPS].x;
            sin_t = -ct_ff[CORDIC_STEPS].y;
         end
         default: begin
            cos_t = ct_ff[CORDIC_STEPS].y;
            sin_t = -ct_ff[CORDIC_STEPS].x;
         end
      endcase
      case (cp_ff[CORDIC_STEPS].quad)
         2'd0: begin
            cos_p = cp_ff[CORDIC_STEPS].x;
            sin_p = cp_ff[CORDIC_STEPS].y;
         end
         2'd1: begin
            cos_p = -cp_ff[CORDIC_STEPS].y;
            sin_p = cp_ff[CORDIC_STEPS].x;
         end
         2'd2: begin
            cos_p = -cp_ff[CORDIC_STEPS].x;
            sin_p = -cp_ff[CORDIC_STEPS].y;
         end
         default: begin
            cos_p = cp_ff[CORDIC_STEPS].y;
            sin_p = -cp_ff[CORDIC_STEPS].x;
         end
      endcase
      nx_in = sin_p * cos_t;
      nz_in = sin_p * sin_t;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= nx_in;
         nz_ff <= nz_in;
         ny_ff <= cos_p;
         side_mul_ff <= side_ff[MUL_STAGE-1];
      end
   end

   // Output stage: rounding and saturation into the result register.
   logic [RSP_DATA_W-1:0] data_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic                  user_ff;
   logic signed [67:0]    ny_wide;

   always_comb begin
      ny_wide = 68'(ny_ff);
      data_in[15:0] = round_sat(nx_ff, 45, 68'sd32767);
      data_in[31:16] = round_sat(ny_wide, 15, 68'sd32767);
      data_in[47:32] = round_sat(nz_ff, 45, 68'sd32767);
      data_in[63:48] = round_sat(nx_ff, 46, 68'sd16384);
      data_in[79:64] = round_sat(ny_wide, 16, 68'sd16384);
      data_in[95:80] = round_sat(nz_ff, 46, 68'sd16384);
      data_in[111:96] = side_mul_ff.tex_u;
      data_in[127:112] = side_mul_ff.tex_v;
      data_in[143:128] = side_mul_ff.top_left;
      data_in[159:144] = side_mul_ff.bottom_left;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
         user_ff <= side_mul_ff.quad_valid;
      end
   end

   assign rsp_tvalid = v_ff[OUT_STAGE];
   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;

endmodule

### rtl/core/uvsph_checker.sv
// ---------------------------------------------------------------------------
// UV sphere vertex generator checker
// Port level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uvsph_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [uvsph_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser
);
   import uvsph_pkg::*;

   // Results never appear in the cycle right after reset.
   `SVA_ALWAYS(a_no_rsp_after_reset, clock, $past(reset), !rsp_tvalid)
   // An empty output register never holds back requests.
   `SVA_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   // A point that starts no quad reports no bottom-left index.
   `SVA_IMPLY(a_no_quad_index, clock, reset, rsp_tvalid && !rsp_tuser,
              rsp_tdata[159:144] == 16'd0)
   // A stalled result stays offered.
   `SVA_IMPLY(a_rsp_held, clock, reset, $past(rsp_tvalid && !rsp_tready) && !$past(reset),
              rsp_tvalid)

endmodule

bind uv_sphere_vertex_generator_unit uvsph_checker u_uvsph_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
